FILE: hdl/bba_pkg.sv
package bba_pkg;

	localparam int TOP_ORDER    = 16;
	localparam int MAX_ORDER    = TOP_ORDER - 1;
	localparam int HEADER_BYTES = 12;
	localparam int MIN_ORDER    = 4;
	localparam int PAGE_ORDER   = 12;
	localparam int ARENA_PAGES  = 16;
	localparam int ADDR_W       = 16;
	localparam int IDX_W        = ADDR_W - MIN_ORDER;
	localparam int TAG_DEPTH    = 1 << IDX_W;
	localparam int TAG_W        = 7;
	localparam int TAG_HEAD     = 6;
	localparam int TAG_USED     = 5;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SWEEP,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SPLIT,
		S_FREE_RD,
		S_FREE_CHK,
		S_MATE_RD,
		S_MATE_CHK,
		S_FREE_WR,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic             en;
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [TAG_W-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_address;
		status_t           status;
	} result_t;

endpackage

FILE: hdl/bba_tag_ram.sv
module bba_tag_ram
	import bba_pkg::*;
(
	input  logic             clk,
	input  ram_req_t         req,
	output logic [TAG_W-1:0] rdata
);

	logic [TAG_W-1:0] mem [TAG_DEPTH];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata <= mem[req.addr];
			end
		end
	end

endmodule

FILE: hdl/bba_ctrl.sv
module bba_ctrl
	import bba_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [4:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmd_t              in_cmd,
	input  logic [ADDR_W-1:0] in_size,
	input  logic [ADDR_W-1:0] in_addr,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res,
	output ram_req_t          ram_req,
	input  logic [TAG_W-1:0]  ram_rdata
);

	state_t state_q, state_d;
	logic [IDX_W:0]    arena_q, arena_d;
	logic [IDX_W-1:0]  g_q, g_d;
	logic [IDX_W:0]    nxt_q, nxt_d;
	logic [IDX_W:0]    a_q, a_d;
	logic [4:0]        need_q, need_d, o_q, o_d, k_q, k_d;
	logic [IDX_W-1:0]  base_q, base_d, mate_q, mate_d;
	logic [ADDR_W-1:0] pay_q, pay_d;
	status_t           stat_q, stat_d;

	logic [4:0]        need_c, ord_c, bo;
	logic [IDX_W:0]    step_c, span_c, ospan_c;
	logic [ADDR_W-1:0] base16;
	logic              free_bad, scan_end, mate_in, merge_ok, t_head, t_used, order_top;
	logic [IDX_W-1:0]  mate_c;
	logic [4:0]        pc_c;

	always_comb begin
		need_c = 5'(TOP_ORDER);
		for (int o = MAX_ORDER; o >= MIN_ORDER; o--) begin
			if ((17'(1) << o) - 17'(HEADER_BYTES) >= {1'b0, in_size})
				need_c = 5'(o);
		end
	end

	always_comb begin
		ord_c = 5'(MIN_ORDER);
		for (int o = MIN_ORDER; o <= MAX_ORDER; o++) begin
			if ((({1'b0, g_q} & ((13'(1) << (o - MIN_ORDER)) - 13'(1))) == '0) &&
			    (14'(g_q) + (14'(1) << (o - MIN_ORDER)) <= 14'(arena_q)))
				ord_c = 5'(o);
		end
	end

	assign pc_c      = (cfg_wdata > 5'(ARENA_PAGES)) ? 5'(ARENA_PAGES) : cfg_wdata;
	assign span_c    = 13'(1) << (ord_c - 5'(MIN_ORDER));
	assign t_head    = ram_rdata[TAG_HEAD];
	assign t_used    = ram_rdata[TAG_USED];
	assign bo        = ram_rdata[4:0];
	assign step_c    = 13'(1) << (bo - 5'(MIN_ORDER));
	assign base16    = in_addr - 16'(HEADER_BYTES);
	assign free_bad  = (in_addr < 16'(HEADER_BYTES)) ||
	                   ({1'b0, base16[ADDR_W-1:MIN_ORDER]} >= arena_q) ||
	                   (base16[MIN_ORDER-1:0] != '0);
	assign scan_end  = (a_q >= arena_q);
	assign ospan_c   = 13'(1) << (o_q - 5'(MIN_ORDER));
	assign mate_c    = base_q ^ ospan_c[IDX_W-1:0];
	assign order_top = (o_q >= 5'(MAX_ORDER));
	assign mate_in   = !order_top && ({1'b0, mate_c} < arena_q) &&
	                   (14'(mate_c) + 14'(ospan_c) <= 14'(arena_q));
	assign merge_ok  = t_head && !t_used && (bo == o_q);

	always_comb begin
		state_d = state_q;
		arena_d = arena_q;
		g_d     = g_q;
		nxt_d   = nxt_q;
		a_d     = a_q;
		need_d  = need_q;
		o_d     = o_q;
		k_d     = k_q;
		base_d  = base_q;
		mate_d  = mate_q;
		pay_d   = pay_q;
		stat_d  = stat_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					pay_d = '0;
					if (in_cmd == CMD_ALLOC) begin
						need_d = need_c;
						o_d    = need_c;
						a_d    = '0;
						if (need_c > 5'(MAX_ORDER)) begin
							stat_d  = ST_NO_SPACE;
							state_d = S_RESULT;
						end else begin
							state_d = S_SCAN_RD;
						end
					end else begin
						base_d = base16[ADDR_W-1:MIN_ORDER];
						if (free_bad) begin
							stat_d  = ST_BAD_FREE;
							state_d = S_RESULT;
						end else begin
							state_d = S_FREE_RD;
						end
					end
				end
			end
			S_SWEEP: begin
				g_d = g_q + 1'b1;
				if ({1'b0, g_q} == nxt_q && {1'b0, g_q} < arena_q)
					nxt_d = nxt_q + span_c;
				if (g_q == '1)
					state_d = S_IDLE;
			end
			S_SCAN_RD: begin
				if (scan_end) begin
					a_d = '0;
					if (o_q >= 5'(MAX_ORDER)) begin
						stat_d  = ST_NO_SPACE;
						state_d = S_RESULT;
					end else begin
						o_d = o_q + 1'b1;
					end
				end else begin
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (!t_head) begin
					stat_d  = ST_NO_SPACE;
					state_d = S_RESULT;
				end else if (bo == o_q && !t_used) begin
					k_d     = o_q;
					state_d = S_SPLIT;
				end else begin
					a_d     = a_q + step_c;
					state_d = S_SCAN_RD;
				end
			end
			S_SPLIT: begin
				if (k_q > need_q) begin
					k_d = k_q - 1'b1;
				end else begin
					pay_d   = {a_q[IDX_W-1:0], MIN_ORDER'(0)} + 16'(HEADER_BYTES);
					stat_d  = ST_DONE;
					state_d = S_RESULT;
				end
			end
			S_FREE_RD: state_d = S_FREE_CHK;
			S_FREE_CHK: begin
				o_d = bo;
				if (!t_head || !t_used) begin
					stat_d  = ST_BAD_FREE;
					state_d = S_RESULT;
				end else begin
					state_d = S_MATE_RD;
				end
			end
			S_MATE_RD: begin
				mate_d  = mate_c;
				state_d = mate_in ? S_MATE_CHK : S_FREE_WR;
			end
			S_MATE_CHK: begin
				if (merge_ok) begin
					if (mate_q < base_q)
						base_d = mate_q;
					o_d     = o_q + 1'b1;
					state_d = S_MATE_RD;
				end else begin
					state_d = S_FREE_WR;
				end
			end
			S_FREE_WR: begin
				stat_d  = ST_DONE;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (cfg_we) begin
			arena_d = {pc_c, 8'(0)};
			g_d     = '0;
			nxt_d   = '0;
			state_d = S_SWEEP;
		end
	end

	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_req   = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_SWEEP: begin
				ram_req.en   = 1'b1;
				ram_req.we   = 1'b1;
				ram_req.addr = g_q;
				if ({1'b0, g_q} == nxt_q && {1'b0, g_q} < arena_q)
					ram_req.wdata = {1'b1, 1'b0, ord_c};
			end
			S_SCAN_RD: begin
				ram_req.en   = !scan_end;
				ram_req.addr = a_q[IDX_W-1:0];
			end
			S_SPLIT: begin
				ram_req.en = 1'b1;
				ram_req.we = 1'b1;
				if (k_q > need_q) begin
					ram_req.addr  = a_q[IDX_W-1:0] +
					                (12'(1) << (k_q - 5'(MIN_ORDER + 1)));
					ram_req.wdata = {1'b1, 1'b0, k_q - 5'd1};
				end else begin
					ram_req.addr  = a_q[IDX_W-1:0];
					ram_req.wdata = {1'b1, 1'b1, need_q};
				end
			end
			S_FREE_RD: begin
				ram_req.en   = 1'b1;
				ram_req.addr = base_q;
			end
			S_MATE_RD: begin
				ram_req.en   = mate_in;
				ram_req.addr = mate_c;
			end
			S_MATE_CHK: begin
				ram_req.en   = merge_ok;
				ram_req.we   = 1'b1;
				ram_req.addr = (mate_q < base_q) ? base_q : mate_q;
			end
			S_FREE_WR: begin
				ram_req.en    = 1'b1;
				ram_req.we    = 1'b1;
				ram_req.addr  = base_q;
				ram_req.wdata = {1'b1, 1'b0, o_q};
			end
			S_RESULT: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res.payload_address = pay_q;
	assign res.status          = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			arena_q <= '0;
		end else begin
			state_q <= state_d;
			arena_q <= arena_d;
		end
	end

	always_ff @(posedge clk) begin
		g_q    <= g_d;
		nxt_q  <= nxt_d;
		a_q    <= a_d;
		need_q <= need_d;
		o_q    <= o_d;
		k_q    <= k_d;
		base_q <= base_d;
		mate_q <= mate_d;
		pay_q  <= pay_d;
		stat_q <= stat_d;
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !(ram_req.en && ram_req.we))
		else $error("tag write while idle");

	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> state_q == S_SWEEP)
		else $error("config write did not start sweep");

	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !cfg_we |=> state_q == S_IDLE)
		else $error("no return to idle after result");

	a_ok_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_DONE |-> res.payload_address == '0)
		else $error("payload set on failure");

endmodule

FILE: hdl/buddy_block_allocator.sv
// channel | dir | signals                          | contents
// s       | in  | s_tvalid s_tready s_tdata s_tuser | request_size, free_address; cmd
// m       | out | m_tvalid m_tready m_tdata         | payload_address, status
// cfg     | in  | cfg_we cfg_wdata                  | page_count
//
// One transfer in at a time; allocate reads and checks one block head at a time
// on each order, then takes one S_SPLIT step per split level, so latency grows
// with fragmentation. Free checks one mate per merge level, then writes the head.
// A page_count write sweeps all 4096 tag entries, one per cycle, s_tready low.
// After reset the arena is empty; no sweep runs.
// Result sits in an output register; a stalled m side holds the next result.
module buddy_block_allocator
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // request_size[15:0], free_address[31:16]
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // payload_address[15:0], status[17:16]
);

	logic             res_valid, res_ready;
	result_t          res, out_q;
	ram_req_t         ram_req;
	logic [TAG_W-1:0] ram_rdata;
	logic             m_valid_q;

	bba_tag_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser)),
		.in_size   (s_tdata[15:0]),
		.in_addr   (s_tdata[31:16]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_q.status, out_q.payload_address};

endmodule

FILE: tb/sv/buddy_block_allocator_tb.sv
module buddy_block_allocator_tb;
	import bba_pkg::*;

	localparam int STALL_LIMIT = 400000;
	localparam int GRAN = 1 << MIN_ORDER;
	localparam int TAGS = ARENA_PAGES << (PAGE_ORDER - MIN_ORDER);
	localparam int RUN_ITEMS = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [23:0] m_tdata;

	typedef struct {
		cmd_t    cmd;
		int      size;
		int      addr;
		bit      typed;
		int      exp_payload;
		status_t exp_status;
	} row_t;

	typedef struct {
		int      payload;
		status_t status;
	} outcome_t;

	logic [6:0] tags [TAGS];
	int         pages;
	int         arena_bytes;
	outcome_t   pending [$];
	int         live [$];
	int         errors = 0;
	int         stalled = 0;
	bit         calm = 1'b0;

	buddy_block_allocator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [6:0] tag_of(int a);
		int g = a >> MIN_ORDER;
		return (g < TAGS) ? tags[g] : 7'd0;
	endfunction

	function automatic void set_tag(int a, logic [6:0] t);
		int g = a >> MIN_ORDER;
		if (g < TAGS)
			tags[g] = t;
	endfunction

	function automatic void rebuild_arena(int value);
		int a = 0;
		int o;
		pages = (value > ARENA_PAGES) ? ARENA_PAGES : value;
		foreach (tags[i])
			tags[i] = '0;
		arena_bytes = pages << PAGE_ORDER;
		while (a < arena_bytes) begin
			o = MAX_ORDER;
			while (o > MIN_ORDER && ((a & ((1 << o) - 1)) != 0 || a + (1 << o) > arena_bytes))
				o--;
			set_tag(a, {1'b1, 1'b0, 5'(o)});
			a += 1 << o;
		end
	endfunction

	function automatic outcome_t allocate_block(int size);
		outcome_t r = '{0, ST_NO_SPACE};
		int need = MIN_ORDER;
		int a;
		logic [6:0] t;
		while (need <= MAX_ORDER && (1 << need) - HEADER_BYTES < size)
			need++;
		if (need > MAX_ORDER)
			return r;
		for (int o = need; o <= MAX_ORDER; o++) begin
			a = 0;
			while (a < arena_bytes) begin
				t = tag_of(a);
				if (!t[TAG_HEAD])
					return r;
				if (int'(t[4:0]) == o && !t[TAG_USED]) begin
					for (int k = o; k > need; k--)
						set_tag(a + (1 << (k - 1)), {1'b1, 1'b0, 5'(k - 1)});
					set_tag(a, {1'b1, 1'b1, 5'(need)});
					r.payload = (a + HEADER_BYTES) & 16'hFFFF;
					r.status = ST_DONE;
					return r;
				end
				a += 1 << t[4:0];
			end
		end
		return r;
	endfunction

	function automatic status_t release_block(int addr);
		int base, o, mate;
		logic [6:0] t, mt;
		if (addr < HEADER_BYTES)
			return ST_BAD_FREE;
		base = addr - HEADER_BYTES;
		if (base >= arena_bytes || (base & (GRAN - 1)) != 0)
			return ST_BAD_FREE;
		t = tag_of(base);
		if (!t[TAG_HEAD] || !t[TAG_USED])
			return ST_BAD_FREE;
		o = t[4:0];
		while (o < MAX_ORDER) begin
			mate = base ^ (1 << o);
			if (mate >= arena_bytes || mate + (1 << o) > arena_bytes)
				break;
			mt = tag_of(mate);
			if (!mt[TAG_HEAD] || mt[TAG_USED] || int'(mt[4:0]) != o)
				break;
			if (mate < base) begin
				set_tag(base, '0);
				base = mate;
			end else begin
				set_tag(mate, '0);
			end
			o++;
		end
		set_tag(base, {1'b1, 1'b0, 5'(o)});
		return ST_DONE;
	endfunction

	function automatic outcome_t predict(cmd_t cmd, int size, int addr);
		outcome_t r;
		if (cmd == CMD_ALLOC) begin
			r = allocate_block(size);
			if (r.status == ST_DONE)
				live.push_back(r.payload);
		end else begin
			r.payload = 0;
			r.status = release_block(addr);
			foreach (live[i])
				if (live[i] == addr && r.status == ST_DONE) begin
					live.delete(i);
					break;
				end
		end
		return r;
	endfunction

	task automatic send(row_t r);
		outcome_t p;
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {r.addr[15:0], r.size[15:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		p = predict(r.cmd, r.size, r.addr);
		if (r.typed) begin
			p.payload = r.exp_payload;
			p.status = r.exp_status;
		end
		pending.push_back(p);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic write_pages(int value);
		s_tvalid <= 1'b0;
		wait (pending.size() == 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[4:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		rebuild_arena(value);
		live.delete();
		repeat (2) @(posedge clk);
	endtask

	function automatic row_t random_item();
		row_t r;
		int k;
		r.typed = 1'b0;
		r.size = $urandom_range(0, 65535);
		r.addr = $urandom_range(0, 65535);
		r.exp_payload = 0;
		r.exp_status = ST_DONE;
		k = $urandom_range(0, 9);
		if (live.size() > 0 && k < 4) begin
			r.cmd = CMD_FREE;
			if ($urandom_range(0, 9) != 0)
				r.addr = live[$urandom_range(0, live.size() - 1)];
		end else if (k < 5) begin
			r.cmd = CMD_FREE;
		end else begin
			r.cmd = CMD_ALLOC;
			k = $urandom_range(0, 9);
			if (k < 6)
				r.size = $urandom_range(0, 500);
			else if (k < 9)
				r.size = $urandom_range(0, 8192);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected result: actual payload %0d status %0d",
					$time, m_tdata[15:0], m_tdata[17:16]);
				errors++;
			end else begin
				outcome_t e;
				e = pending.pop_front();
				if (m_tdata[15:0] !== e.payload[15:0]) begin
					$display("%0t payload_address: expected %0d actual %0d",
						$time, e.payload, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[17:16] !== e.status) begin
					$display("%0t status: expected %0d actual %0d",
						$time, e.status, m_tdata[17:16]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stalled <= 0;
		else
			stalled <= stalled + 1;
		if (stalled > STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		row_t directed [$];
		int   phase_pages [7] = '{16, 31, 0, 1, 5, 3, 16};
		rebuild_arena(0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty arena after reset
		send('{CMD_ALLOC, 0, 0, 1'b1, 0, ST_NO_SPACE});
		send('{CMD_FREE, 0, 12, 1'b1, 0, ST_BAD_FREE});
		write_pages(16);
		directed = '{
			'{CMD_ALLOC, 0, 16'hFFFF, 1'b1, 12, ST_DONE},
			'{CMD_ALLOC, 65535, 0, 1'b1, 0, ST_NO_SPACE},
			'{CMD_ALLOC, 32756, 0, 1'b1, 32780, ST_DONE},
			'{CMD_ALLOC, 32757, 0, 1'b1, 0, ST_NO_SPACE},
			'{CMD_FREE, 0, 0, 1'b1, 0, ST_BAD_FREE},
			'{CMD_FREE, 0, 11, 1'b1, 0, ST_BAD_FREE},
			'{CMD_FREE, 0, 20, 1'b1, 0, ST_BAD_FREE},
			'{CMD_FREE, 0, 65535, 1'b1, 0, ST_BAD_FREE},
			'{CMD_FREE, 0, 28, 1'b1, 0, ST_BAD_FREE},
			'{CMD_FREE, 0, 12, 1'b1, 0, ST_DONE},
			'{CMD_FREE, 0, 12, 1'b1, 0, ST_BAD_FREE},
			'{CMD_ALLOC, 4, 0, 1'b0, 0, ST_DONE},
			'{CMD_ALLOC, 5, 0, 1'b0, 0, ST_DONE},
			'{CMD_ALLOC, 4, 0, 1'b0, 0, ST_DONE},
			'{CMD_ALLOC, 4084, 0, 1'b0, 0, ST_DONE},
			'{CMD_FREE, 0, 28, 1'b0, 0, ST_DONE},
			'{CMD_FREE, 0, 12, 1'b0, 0, ST_DONE},
			'{CMD_FREE, 0, 32780, 1'b1, 0, ST_DONE},
			'{CMD_ALLOC, 16'hAAAA, 16'h5555, 1'b0, 0, ST_DONE},
			'{CMD_FREE, 16'h5555, 16'hAAAA, 1'b0, 0, ST_DONE}
		};
		foreach (directed[i])
			send(directed[i]);

		foreach (phase_pages[p]) begin
			write_pages(phase_pages[p]);
			if (p == 6)
				calm = 1'b1;
			repeat (RUN_ITEMS)
				send(random_item());
		end
		s_tvalid <= 1'b0;
		wait (pending.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hdl/bba_pkg.sv
hdl/bba_tag_ram.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator.sv
tb/sv/buddy_block_allocator_tb.sv
